>>> hw/rtl/sip_pkg.sv
// Shared types and constants for the sector interleave position generator.
package sip_pkg;

   // Request beat: one track to lay out.
   typedef struct packed {
      logic [6:0] track_number;
      logic [5:0] sectors_in_track;
   } req_type;

   // Response beat: one placed sector.
   typedef struct packed {
      logic [4:0]  sector_order;
      logic [4:0]  slot_taken;
      logic [15:0] position;
      logic        last;
   } rsp_type;

   // Configuration register indexes.
   localparam logic CSR_MODE         = 1'b0;
   localparam logic CSR_SECTOR_BYTES = 1'b1;

   // Mode codes.
   localparam logic [1:0] MODE_AUTO       = 2'd0;
   localparam logic [1:0] MODE_FORCE_AUTO = 2'd1;
   localparam logic [1:0] MODE_NONE       = 2'd2;
   localparam logic [1:0] MODE_HALF_HD    = 2'd3;

   // Sector sizes that change the interleave.
   localparam logic [10:0] SECTOR_128 = 11'd128;
   localparam logic [10:0] SECTOR_256 = 11'd256;

   // Track skew (0.08 rev) and slot span (0.98 rev) in 1/65536 revolution.
   localparam logic [15:0] SKEW_PER_TRACK = 16'd5243;
   localparam logic [15:0] SPAN_NUM       = 16'd64225;

   // Interleave for 256-byte sectors: (15n + 17) / 18.
   localparam logic [4:0] IL256_MUL = 5'd15;
   localparam logic [4:0] IL256_ADD = 5'd17;
   localparam logic [4:0] IL256_DIV = 5'd18;

endpackage

>>> hw/rtl/sector_interleave_positions.sv
// Top level: sector interleave and track skew position generator.
//
//   channel  dir  handshake              payload
//   req_     in   req_valid / req_stall  sip_pkg::req_type (track, sector count)
//   rsp_     out  rsp_valid / rsp_stall  sip_pkg::rsp_type (order, slot, position, last)
//   csr_     in   csr_valid / csr_ready  csr_index (0 mode, 1 sector_bytes), csr_data
//
// One shared restoring divider (one quotient bit per cycle, DVD_W = 16 + clog2(MAX_SECTORS)
// bits, 21 for the default) does all the divisions. A request is accepted, then one divider
// pass finds the interleave step; then for each sector a probe walks past taken slots, one
// divider pass finds the slot angle, and the output beat is held until the receiver takes it.
// Synchronous active-high reset returns to idle, mode auto and 128-byte sectors.
// req_stall is high from the accepted request until its last beat leaves; a stalled
// response holds its payload. A request of zero sectors gives no beats.
module sector_interleave_positions #(
   parameter int MAX_SECTORS = 32
) (
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_valid,
   output logic                req_stall,
   input  sip_pkg::req_type    req_data,
   // response channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output sip_pkg::rsp_type    rsp_data,
   // configuration writes
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic                csr_index,
   input  logic [10:0]         csr_data
);
   import sip_pkg::*;

   // Slot index and sector count widths follow from the slot count.
   localparam int PTR_W = (MAX_SECTORS > 1) ? $clog2(MAX_SECTORS) : 1;
   localparam int CNT_W = $clog2(MAX_SECTORS + 1);
   // Divisor holds n or a constant of at most 18; dividend holds at most 64225 * slot.
   localparam int DVS_W = (CNT_W > 5) ? CNT_W : 5;
   localparam int DVD_W = 16 + PTR_W;
   localparam int BIT_W = $clog2(DVD_W + 1);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_STEP  = 5'b00010,
      ST_PROBE = 5'b00100,
      ST_POS   = 5'b01000,
      ST_OUT   = 5'b10000
   } state_type;

   state_type            state_ff, state_in;
   logic [1:0]           mode_ff, mode_in;
   logic [10:0]          bytes_ff, bytes_in;
   logic [MAX_SECTORS-1:0] used_ff, used_in;
   logic [CNT_W-1:0]     n_ff, n_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [CNT_W-1:0]     step_ff, step_in;
   logic [PTR_W-1:0]     ptr_ff, ptr_in;
   logic [15:0]          base_ff, base_in;
   logic [DVD_W-1:0]     quo_ff, quo_in;
   logic [DVS_W-1:0]     rem_ff, rem_in;
   logic [DVS_W-1:0]     dvs_ff, dvs_in;
   logic [BIT_W-1:0]     bit_ff, bit_in;
   rsp_type              rsp_ff, rsp_in;

   // Decode of an incoming request.
   logic [CNT_W-1:0]     n_sat;
   logic                 skew_en;
   logic [DVD_W-1:0]     step_dvd;
   logic [DVS_W-1:0]     step_dvs;
   logic [22:0]          skew_prod;

   // Shared divider datapath.
   logic [DVS_W:0]       rem_sh;
   logic                 div_ge;
   logic [DVS_W-1:0]     rem_nx;
   logic [DVD_W-1:0]     quo_nx;
   logic                 div_last;

   // Slot walk.
   logic [CNT_W:0]       ptr_adv;
   logic [CNT_W-1:0]     ptr_inc;
   logic [31:0]          ord_wide;
   logic [31:0]          slot_wide;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

   // Saturate the sector count to the slot map size.
   assign n_sat = (32'(req_data.sectors_in_track) > MAX_SECTORS) ?
                  CNT_W'(MAX_SECTORS) : CNT_W'(req_data.sectors_in_track);

   // Pick the interleave as a division job and decide on the skew.
   always_comb begin
      skew_en  = 1'b0;
      step_dvd = DVD_W'(1);
      step_dvs = DVS_W'(1);
      case (mode_ff)
         MODE_AUTO, MODE_FORCE_AUTO: begin
            if (bytes_ff == SECTOR_128) begin
               skew_en  = 1'b1;
               step_dvd = DVD_W'(n_sat) + DVD_W'(1);
               step_dvs = DVS_W'(2);
            end else if (bytes_ff == SECTOR_256) begin
               skew_en  = 1'b1;
               step_dvd = DVD_W'(IL256_MUL) * DVD_W'(n_sat) + DVD_W'(IL256_ADD);
               step_dvs = DVS_W'(IL256_DIV);
            end
         end
         MODE_NONE: begin
            skew_en = 1'b0;
         end
         MODE_HALF_HD: begin
            skew_en  = 1'b1;
            step_dvd = DVD_W'(n_sat) + DVD_W'(1);
            step_dvs = DVS_W'(2);
         end
         default: begin
            skew_en = 1'b0;
         end
      endcase
   end

   assign skew_prod = 23'(SKEW_PER_TRACK) * 23'(req_data.track_number);

   // One restoring step: shift in the next dividend bit, subtract if it fits.
   assign rem_sh   = {rem_ff, quo_ff[DVD_W-1]};
   assign div_ge   = (rem_sh >= {1'b0, dvs_ff});
   assign rem_nx   = div_ge ? DVS_W'(rem_sh - {1'b0, dvs_ff}) : DVS_W'(rem_sh);
   assign quo_nx   = {quo_ff[DVD_W-2:0], div_ge};
   assign div_last = (bit_ff == BIT_W'(1));

   // Next slot after a collision and after a placed sector, both wrapping at n.
   assign ptr_inc = CNT_W'(ptr_ff) + CNT_W'(1);
   always_comb begin
      ptr_adv = (CNT_W+1)'(ptr_ff) + (CNT_W+1)'(step_ff);
      if (ptr_adv >= (CNT_W+1)'(n_ff)) begin
         ptr_adv = ptr_adv - (CNT_W+1)'(n_ff);
      end
   end

   assign ord_wide  = 32'(cnt_ff);
   assign slot_wide = 32'(ptr_ff);

   always_comb begin
      state_in = state_ff;
      mode_in  = mode_ff;
      bytes_in = bytes_ff;
      used_in  = used_ff;
      n_in     = n_ff;
      cnt_in   = cnt_ff;
      step_in  = step_ff;
      ptr_in   = ptr_ff;
      base_in  = base_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      bit_in   = bit_ff;
      rsp_in   = rsp_ff;

      // Register writes must arrive only while idle; the block itself does not enforce this.
      if (csr_valid && csr_ready) begin
         if (csr_index == CSR_MODE) begin
            mode_in = csr_data[1:0];
         end else if (csr_index == CSR_SECTOR_BYTES) begin
            bytes_in = csr_data;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               // Clear the slot map and start the interleave division.
               used_in = '0;
               ptr_in  = '0;
               cnt_in  = '0;
               n_in    = n_sat;
               base_in = skew_en ? skew_prod[15:0] : 16'd0;
               quo_in  = step_dvd;
               rem_in  = '0;
               dvs_in  = step_dvs;
               bit_in  = BIT_W'(DVD_W);
               if (n_sat != '0) begin
                  state_in = ST_STEP;
               end
            end
         end
         ST_STEP: begin
            quo_in = quo_nx;
            rem_in = rem_nx;
            bit_in = bit_ff - BIT_W'(1);
            if (div_last) begin
               // Step never exceeds n; a step of n wraps to zero.
               step_in  = (quo_nx >= DVD_W'(n_ff)) ? '0 : CNT_W'(quo_nx);
               state_in = ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (used_ff[ptr_ff]) begin
               ptr_in = (ptr_inc == n_ff) ? '0 : PTR_W'(ptr_inc);
            end else begin
               // Claim the slot and divide 64225 * slot by n.
               used_in[ptr_ff] = 1'b1;
               quo_in   = DVD_W'(SPAN_NUM) * DVD_W'(ptr_ff);
               rem_in   = '0;
               dvs_in   = DVS_W'(n_ff);
               bit_in   = BIT_W'(DVD_W);
               state_in = ST_POS;
            end
         end
         ST_POS: begin
            quo_in = quo_nx;
            rem_in = rem_nx;
            bit_in = bit_ff - BIT_W'(1);
            if (div_last) begin
               rsp_in.sector_order = ord_wide[4:0];
               rsp_in.slot_taken   = slot_wide[4:0];
               rsp_in.position     = base_ff + quo_nx[15:0];
               rsp_in.last         = (cnt_ff == n_ff - CNT_W'(1));
               state_in            = ST_OUT;
            end
         end
         ST_OUT: begin
            // Hold the beat until taken, then advance to the next sector.
            if (!rsp_stall) begin
               if (rsp_ff.last) begin
                  state_in = ST_IDLE;
               end else begin
                  cnt_in   = cnt_ff + CNT_W'(1);
                  ptr_in   = PTR_W'(ptr_adv);
                  state_in = ST_PROBE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mode_ff  <= MODE_AUTO;
         bytes_ff <= SECTOR_128;
         used_ff  <= '0;
         n_ff     <= '0;
         cnt_ff   <= '0;
         step_ff  <= '0;
         ptr_ff   <= '0;
         bit_ff   <= '0;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
         bytes_ff <= bytes_in;
         used_ff  <= used_in;
         n_ff     <= n_in;
         cnt_ff   <= cnt_in;
         step_ff  <= step_in;
         ptr_ff   <= ptr_in;
         bit_ff   <= bit_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff <= base_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      rsp_ff  <= rsp_in;
   end

   // A nonempty request locks out the next one.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.sectors_in_track != '0 |=> req_stall)
      else $error("request accepted without going busy");

   // The final beat leaving frees the request side.
   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_data.last |=> !req_stall)
      else $error("not idle after last beat");

   // An emitted slot lies inside the track and is marked taken.
   a_slot_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_OUT |-> CNT_W'(ptr_ff) < n_ff && used_ff[ptr_ff])
      else $error("emitted slot out of range or not claimed");

   // Partial remainder stays below the divisor.
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_STEP || state_ff == ST_POS |-> rem_ff < dvs_ff)
      else $error("divider remainder out of bound");

endmodule
